[hw/rtl/binomial_tree_gather_schedule_top_macros.svh]
// Assertion macros shared by the binomial-tree gather schedule RTL.
`ifndef BINOMIAL_TREE_GATHER_SCHEDULE_TOP_MACROS_SVH
`define BINOMIAL_TREE_GATHER_SCHEDULE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BTG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/btg_pkg.sv]
// Shared types and constants of the binomial-tree gather schedule block.
package btg_pkg;

	localparam int RANK_W        = 10;
	localparam int SIZE_W        = 11;
	localparam int MASK_W        = 12;
	localparam int CNT_W         = 16;
	localparam int ENT_W         = 11;
	localparam int ELEM_W        = 26;
	localparam int KIND_W        = 2;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int IN_TDATA_W    = 16;
	localparam int OUT_TDATA_W   = 40;
	localparam int QUEUE_DEPTH   = 2;
	localparam int DEF_MAX_RANKS = 1024;

	typedef enum logic [KIND_W-1:0] {
		ACT_RECV = 2'd0,
		ACT_SEND = 2'd1,
		ACT_DONE = 2'd2
	} action_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COMM_SIZE  = 2'd0,
		CFG_ROOT_RANK  = 2'd1,
		CFG_RECV_COUNT = 2'd2,
		CFG_SEND_COUNT = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		F_IDLE = 2'd0,
		F_MOD  = 2'd1,
		F_PUSH = 2'd2
	} front_state_t;

	// One classified request: everything the back end needs to walk the tree.
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [RANK_W-1:0] root;
		logic [SIZE_W-1:0] rel;
		logic [MASK_W-1:0] keymask;
	} job_t;

	// Queue status as seen from the front and the back.
	typedef struct packed {
		logic full;
		logic valid;
	} queue_status_t;

	// One schedule entry before the element count is multiplied out.
	typedef struct packed {
		action_kind_t      kind;
		logic [RANK_W-1:0] peer;
		logic [ENT_W-1:0]  entries;
		logic [CNT_W-1:0]  count;
		logic              last;
	} item_t;

endpackage

[hw/rtl/btg_front.sv]
// Front end: accepts a rank, reduces rank and root modulo the size, classifies the request.
`include "binomial_tree_gather_schedule_top_macros.svh"

module btg_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [btg_pkg::RANK_W-1:0]    in_rank,
	input  logic [btg_pkg::SIZE_W-1:0]    eff_size,
	input  logic [btg_pkg::RANK_W-1:0]    root_rank,
	input  btg_pkg::queue_status_t        q_status,
	output logic                          push,
	output btg_pkg::job_t                 push_job
);

	localparam int STEPS = btg_pkg::RANK_W;
	localparam int CNT_CW = $clog2(STEPS + 1);

	btg_pkg::front_state_t state_q, state_d;
	logic [CNT_CW-1:0]           cnt_q;
	logic [btg_pkg::RANK_W-1:0]  me_sh_q, root_sh_q;
	logic [btg_pkg::SIZE_W-1:0]  rem_me_q, rem_root_q, size_q;

	logic [btg_pkg::SIZE_W:0]    t_me, t_root, size_x;
	logic [btg_pkg::SIZE_W-1:0]  rem_me_nx, rem_root_nx;
	logic [btg_pkg::SIZE_W:0]    diff;
	logic [btg_pkg::SIZE_W-1:0]  rel;
	logic [btg_pkg::MASK_W-1:0]  km_root;
	logic                        last_step;

	// Restoring remainder step, one dividend bit per cycle for both operands.
	always_comb begin
		size_x      = {1'b0, size_q};
		t_me        = {rem_me_q, me_sh_q[btg_pkg::RANK_W-1]};
		t_root      = {rem_root_q, root_sh_q[btg_pkg::RANK_W-1]};
		rem_me_nx   = (t_me >= size_x) ? btg_pkg::SIZE_W'(t_me - size_x)
		                               : btg_pkg::SIZE_W'(t_me);
		rem_root_nx = (t_root >= size_x) ? btg_pkg::SIZE_W'(t_root - size_x)
		                                 : btg_pkg::SIZE_W'(t_root);
		last_step   = (cnt_q == CNT_CW'(STEPS - 1));
	end

	// Classification from the reduced rank and root.
	always_comb begin
		diff = {1'b0, rem_me_q} + size_x - {1'b0, rem_root_q};
		rel  = (diff >= size_x) ? btg_pkg::SIZE_W'(diff - size_x)
		                        : btg_pkg::SIZE_W'(diff);
		km_root = '0;
		for (int i = 0; i < btg_pkg::SIZE_W; i++) begin
			if (size_q[i]) begin
				km_root = btg_pkg::MASK_W'(2) << i;
			end
		end
		push_job.size    = size_q;
		push_job.root    = rem_root_q[btg_pkg::RANK_W-1:0];
		push_job.rel     = rel;
		push_job.keymask = (rel == '0) ? km_root
		                  : {1'b0, rel & (~rel + btg_pkg::SIZE_W'(1))};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			btg_pkg::F_IDLE: if (in_valid) state_d = btg_pkg::F_MOD;
			btg_pkg::F_MOD:  if (last_step) state_d = btg_pkg::F_PUSH;
			btg_pkg::F_PUSH: if (!q_status.full) state_d = btg_pkg::F_IDLE;
			default:         state_d = btg_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		push     = 1'b0;
		case (state_q)
			btg_pkg::F_IDLE: in_ready = 1'b1;
			btg_pkg::F_PUSH: push = !q_status.full;
			default: begin
				in_ready = 1'b0;
				push     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btg_pkg::F_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == btg_pkg::F_IDLE) begin
				cnt_q <= '0;
			end else if (state_q == btg_pkg::F_MOD) begin
				cnt_q <= cnt_q + CNT_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == btg_pkg::F_IDLE && in_valid) begin
			me_sh_q    <= in_rank;
			root_sh_q  <= root_rank;
			size_q     <= eff_size;
			rem_me_q   <= '0;
			rem_root_q <= '0;
		end else if (state_q == btg_pkg::F_MOD) begin
			me_sh_q    <= me_sh_q << 1;
			root_sh_q  <= root_sh_q << 1;
			rem_me_q   <= rem_me_nx;
			rem_root_q <= rem_root_nx;
		end
	end

	`BTG_ASSERT_IMP(a_rem_below_size, clk, arst_n, state_q == btg_pkg::F_PUSH, (rem_me_q < size_q) && (rem_root_q < size_q), "front: remainder not below size")

endmodule

[hw/rtl/btg_queue.sv]
// Short job queue between the front end and the back end.
`include "binomial_tree_gather_schedule_top_macros.svh"

module btg_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  btg_pkg::job_t          push_job,
	input  logic                   pop,
	output btg_pkg::job_t          head,
	output btg_pkg::queue_status_t status
);

	localparam int PTR_W = (btg_pkg::QUEUE_DEPTH > 1) ? $clog2(btg_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(btg_pkg::QUEUE_DEPTH + 1);

	btg_pkg::job_t      mem_q [btg_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	always_comb begin
		status.full  = (count_q == CNT_W'(btg_pkg::QUEUE_DEPTH));
		status.valid = (count_q != '0);
		head         = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(btg_pkg::QUEUE_DEPTH - 1)) ? '0
				                                                          : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(btg_pkg::QUEUE_DEPTH - 1)) ? '0
				                                                          : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	`BTG_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !status.full, "queue: push while full")
	`BTG_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, status.valid, "queue: pop while empty")

endmodule

[hw/rtl/btg_back.sv]
// Back end: walks the head job's tree distances, emits one beat per cycle unless stalled.
`include "binomial_tree_gather_schedule_top_macros.svh"

module btg_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  btg_pkg::queue_status_t            q_status,
	input  btg_pkg::job_t                     head,
	output logic                              pop,
	input  logic [btg_pkg::CNT_W-1:0]         recv_count,
	input  logic [btg_pkg::CNT_W-1:0]         send_count,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [btg_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tlast,
	output logic [btg_pkg::KIND_W-1:0]        m_tuser
);

	localparam int MW  = btg_pkg::MASK_W;
	localparam int PRW = btg_pkg::ENT_W + btg_pkg::CNT_W;
	localparam int PAD = btg_pkg::OUT_TDATA_W - btg_pkg::ELEM_W - btg_pkg::RANK_W;

	logic [MW-1:0]  dist_q;
	logic           valid_s1;
	btg_pkg::item_t item_s1, item_d;
	logic           out_valid_q;
	logic           out_last_q;
	logic [btg_pkg::KIND_W-1:0]  out_kind_q;
	logic [btg_pkg::RANK_W-1:0]  out_peer_q;
	logic [btg_pkg::ELEM_W-1:0]  out_elem_q;

	logic           ready_out, ready_s1, fire, recv_ok;
	logic [MW-1:0]  size_x, child, parent, base, psum, peer_full;
	logic [MW:0]    recv_sum, send_sum;
	logic [btg_pkg::ENT_W-1:0] recv_ent, send_ent;
	logic [PRW-1:0] prod_s1;

	always_comb begin
		ready_out = !out_valid_q || m_tready;
		ready_s1  = !valid_s1 || ready_out;
		fire      = q_status.valid && ready_s1;

		size_x  = MW'(head.size);
		child   = MW'(head.rel) + dist_q;
		recv_ok = (dist_q < head.keymask) && (child < size_x);

		recv_sum = (MW + 1)'(child) + (MW + 1)'(dist_q);
		recv_ent = (recv_sum <= (MW + 1)'(head.size)) ? btg_pkg::ENT_W'(dist_q)
		                                               : btg_pkg::ENT_W'(size_x - child);
		parent   = MW'(head.rel) - head.keymask;
		send_sum = (MW + 1)'(head.rel) + (MW + 1)'(head.keymask);
		send_ent = (send_sum <= (MW + 1)'(head.size)) ? btg_pkg::ENT_W'(head.keymask)
		                                               : btg_pkg::ENT_W'(head.size - head.rel);

		// Child or parent rank back to absolute numbering.
		base      = recv_ok ? child : parent;
		psum      = base + MW'(head.root);
		peer_full = (psum >= size_x) ? psum - size_x : psum;

		item_d.peer    = btg_pkg::RANK_W'(peer_full);
		if (recv_ok) begin
			item_d.kind    = btg_pkg::ACT_RECV;
			item_d.entries = recv_ent;
			item_d.count   = recv_count;
			item_d.last    = 1'b0;
		end else if (head.rel != '0) begin
			item_d.kind    = btg_pkg::ACT_SEND;
			item_d.entries = send_ent;
			item_d.count   = send_count;
			item_d.last    = 1'b1;
		end else begin
			item_d.kind    = btg_pkg::ACT_DONE;
			item_d.peer    = '0;
			item_d.entries = '0;
			item_d.count   = '0;
			item_d.last    = 1'b1;
		end

		pop = fire && !recv_ok;
	end

	assign prod_s1 = PRW'(item_s1.entries) * PRW'(item_s1.count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q      <= MW'(1);
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				dist_q <= recv_ok ? (dist_q << 1) : MW'(1);
			end
			if (ready_s1) begin
				valid_s1 <= fire;
			end
			if (ready_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			item_s1 <= item_d;
		end
		if (ready_out && valid_s1) begin
			out_kind_q <= item_s1.kind;
			out_peer_q <= item_s1.peer;
			out_elem_q <= prod_s1[btg_pkg::ELEM_W-1:0];
			out_last_q <= item_s1.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD{1'b0}}, out_elem_q, out_peer_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_kind_q;

	`BTG_ASSERT_IMP(a_dist_onehot, clk, arst_n, 1'b1, $onehot(dist_q), "back: distance not a power of two")
	`BTG_ASSERT_IMP(a_done_payload, clk, arst_n, m_tvalid && (m_tuser == btg_pkg::ACT_DONE), (m_tdata == '0) && m_tlast, "back: completion beat carries data")

endmodule

[hw/rtl/binomial_tree_gather_schedule_top.sv]
// Top level of the binomial-tree gather schedule block.
// Each input beat carries one absolute rank; the block answers with that rank's
// binomial-tree gather schedule toward root_rank: one receive beat per child in
// ascending distance (child rank and child subtree size times recv_count), then
// either a send beat to the parent (subtree size times send_count) or, at the
// root, a completion beat with zero rank and count. tlast marks the final beat.
// A front end reduces rank and root modulo the size with a bit-serial remainder
// unit and then classifies the request; it takes a new request only after the
// previous one has entered a two-entry queue, where requests wait. The back end
// emits one beat per cycle while the output is not stalled (a schedule has at
// most 11 beats for 1024 ranks). The first beat passes a staging register and
// the count multiplier register before it appears. Configuration must be
// written by the user only while no request is in flight; the block itself does
// not enforce it. A size of zero counts as one and sizes above MAX_RANKS
// saturate to MAX_RANKS.

module binomial_tree_gather_schedule_top #(
	parameter int MAX_RANKS = btg_pkg::DEF_MAX_RANKS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [btg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [btg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	// Request stream.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [btg_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [9:0] my_rank
	// Schedule stream.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [btg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [9:0] peer_rank, [35:10] element_count
	output logic                                m_axis_tlast,   // last_item
	output logic [btg_pkg::KIND_W-1:0]          m_axis_tuser    // [1:0] action_kind
);

	logic [btg_pkg::SIZE_W-1:0] comm_size_q;
	logic [btg_pkg::RANK_W-1:0] root_rank_q;
	logic [btg_pkg::CNT_W-1:0]  recv_count_q;
	logic [btg_pkg::CNT_W-1:0]  send_count_q;
	logic [btg_pkg::SIZE_W-1:0] eff_size;

	logic                   push, pop;
	btg_pkg::job_t          push_job, head;
	btg_pkg::queue_status_t q_status;

	// Register file; all four indexes are defined, so every write lands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comm_size_q  <= btg_pkg::SIZE_W'(1);
			root_rank_q  <= '0;
			recv_count_q <= '0;
			send_count_q <= '0;
		end else if (cfg_we) begin
			case (btg_pkg::cfg_index_t'(cfg_index))
				btg_pkg::CFG_COMM_SIZE:  comm_size_q  <= cfg_wdata[btg_pkg::SIZE_W-1:0];
				btg_pkg::CFG_ROOT_RANK:  root_rank_q  <= cfg_wdata[btg_pkg::RANK_W-1:0];
				btg_pkg::CFG_RECV_COUNT: recv_count_q <= cfg_wdata[btg_pkg::CNT_W-1:0];
				btg_pkg::CFG_SEND_COUNT: send_count_q <= cfg_wdata[btg_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective size: zero means one rank, anything past MAX_RANKS saturates.
	always_comb begin
		if (comm_size_q == '0) begin
			eff_size = btg_pkg::SIZE_W'(1);
		end else if (32'(comm_size_q) > 32'(MAX_RANKS)) begin
			eff_size = btg_pkg::SIZE_W'(MAX_RANKS);
		end else begin
			eff_size = comm_size_q;
		end
	end

	btg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_rank   (s_axis_tdata[btg_pkg::RANK_W-1:0]),
		.eff_size  (eff_size),
		.root_rank (root_rank_q),
		.q_status  (q_status),
		.push      (push),
		.push_job  (push_job)
	);

	btg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	btg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.head       (head),
		.pop        (pop),
		.recv_count (recv_count_q),
		.send_count (send_count_q),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tlast    (m_axis_tlast),
		.m_tuser    (m_axis_tuser)
	);

endmodule

[bench/testbench.sv]
// Self-checking testbench for the binomial-tree gather schedule block.
`timescale 1ns / 100ps

module testbench;

	localparam int MAX_RANKS      = btg_pkg::DEF_MAX_RANKS;
	// The longest quiet stretch of a correct run is the front end, the path to the
	// first beat, a receiver stall and a sender gap added up; the limit is many
	// times that.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PHASES  = 14;
	localparam int PHASE_ITEMS    = 25;

	// One schedule beat as it leaves the block, split into its fields.
	typedef struct packed {
		btg_pkg::action_kind_t      kind;
		logic [btg_pkg::RANK_W-1:0] peer;
		logic [btg_pkg::ELEM_W-1:0] count;
		logic                       is_last;
	} sched_beat_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [btg_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [btg_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [btg_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [9:0] my_rank
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [btg_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // [9:0] peer_rank, [35:10] element_count
	logic                            m_axis_tlast;        // last_item
	logic [btg_pkg::KIND_W-1:0]      m_axis_tuser;        // [1:0] action_kind

	// Shadow copies of the configuration registers, at register width.
	logic [btg_pkg::SIZE_W-1:0] shadow_comm_size  = 11'd1;
	logic [btg_pkg::RANK_W-1:0] shadow_root_rank  = '0;
	logic [btg_pkg::CNT_W-1:0]  shadow_recv_count = '0;
	logic [btg_pkg::CNT_W-1:0]  shadow_send_count = '0;

	logic [btg_pkg::RANK_W-1:0] pending_ranks[$];   // ranks still to be offered to the block
	sched_beat_t                schedule_beats[$];  // beats the block still owes, oldest first

	int          mismatches   = 0;
	int          burst_left   = 1;
	int          gap_left     = 0;
	int          rx_mode      = 0;
	int          rx_hold      = 0;
	int unsigned quiet_cycles = 0;

	binomial_tree_gather_schedule_top #(
		.MAX_RANKS(MAX_RANKS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Size actually used by the tree: zero counts as one, large sizes saturate.
	function automatic int unsigned effective_size(input logic [btg_pkg::SIZE_W-1:0] raw);
		int unsigned size;
		size = 32'(raw);
		if (size == 0)
			size = 1;
		if (size > MAX_RANKS)
			size = MAX_RANKS;
		return size;
	endfunction

	// Append a rank to the requests still to be offered.
	function automatic void queue_rank(input logic [btg_pkg::RANK_W-1:0] rank);
		pending_ranks.insert(pending_ranks.size(), rank);
	endfunction

	// Append a beat to the predictions still outstanding.
	function automatic void queue_beat(input sched_beat_t beat);
		schedule_beats.insert(schedule_beats.size(), beat);
	endfunction

	// Walk the binomial tree for one rank and queue the beats it must produce.
	// Children sit at distances 1, 2, 4, ... below the lowest set bit of the
	// relative rank (below the next power of two above the size at the root),
	// and the walk stops at the first child that falls outside the group.
	function automatic void push_gather_schedule(input logic [btg_pkg::RANK_W-1:0] rank);
		int unsigned size, me, root, rel, keymask, hop, child, entries, v;
		sched_beat_t beat;
		size = effective_size(shadow_comm_size);
		me   = rank % size;
		root = shadow_root_rank % size;
		rel  = (me + size - root) % size;
		if (rel == 0) begin
			keymask = 1;
			v = size;
			while (v != 0) begin
				keymask = keymask << 1;
				v = v >> 1;
			end
		end else begin
			keymask = rel & (~rel + 1);
		end
		for (hop = 1; hop < keymask && rel + hop < size; hop = hop << 1) begin
			child = rel + hop;
			entries = (child + hop <= size) ? hop : size - child;
			beat.kind    = btg_pkg::ACT_RECV;
			beat.peer    = btg_pkg::RANK_W'((child + root) % size);
			beat.count   = btg_pkg::ELEM_W'(entries * shadow_recv_count);
			beat.is_last = 1'b0;
			queue_beat(beat);
		end
		if (rel != 0) begin
			entries = (rel + keymask <= size) ? keymask : size - rel;
			beat.kind    = btg_pkg::ACT_SEND;
			beat.peer    = btg_pkg::RANK_W'((rel - keymask + root) % size);
			beat.count   = btg_pkg::ELEM_W'(entries * shadow_send_count);
			beat.is_last = 1'b1;
		end else begin
			beat.kind    = btg_pkg::ACT_DONE;
			beat.peer    = '0;
			beat.count   = '0;
			beat.is_last = 1'b1;
		end
		queue_beat(beat);
	endfunction

	// Request driver: bursts of random length separated by random gaps. A beat
	// offered stays up until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			burst_left = $urandom_range(1, 20);
			gap_left   = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				push_gather_schedule(s_axis_tdata[btg_pkg::RANK_W-1:0]);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_ranks.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {{(btg_pkg::IN_TDATA_W-btg_pkg::RANK_W){1'b0}},
						pending_ranks.pop_front()};
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// A quarter of the bursts run straight into the next one.
						burst_left = $urandom_range(1, 20);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Schedule monitor. The receiver switches between stretches that are always
	// ready, randomly ready, mostly stalled and fully stalled. Every accepted
	// beat is checked against the oldest outstanding prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_mode = 0;
			rx_hold = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (schedule_beats.size() == 0) begin
					mismatches++;
					$display("%0t: beat with nothing expected: kind %0d peer %0d count %0d last %0d",
						$time, m_axis_tuser, m_axis_tdata[btg_pkg::RANK_W-1:0],
						m_axis_tdata[btg_pkg::RANK_W+btg_pkg::ELEM_W-1:btg_pkg::RANK_W],
						m_axis_tlast);
				end else begin
					sched_beat_t want, got;
					want = schedule_beats.pop_front();
					got.kind    = btg_pkg::action_kind_t'(m_axis_tuser);
					got.peer    = m_axis_tdata[btg_pkg::RANK_W-1:0];
					got.count   = m_axis_tdata[btg_pkg::RANK_W+btg_pkg::ELEM_W-1:btg_pkg::RANK_W];
					got.is_last = m_axis_tlast;
					if (got !== want) begin
						mismatches++;
						$display({"%0t: expected kind %0d peer %0d count %0d last %0d,",
							" got kind %0d peer %0d count %0d last %0d"},
							$time, want.kind, want.peer, want.count, want.is_last,
							got.kind, got.peer, got.count, got.is_last);
					end
				end
			end
			if (rx_hold != 0) begin
				rx_hold--;
			end else begin
				rx_mode = $urandom_range(0, 3);
				rx_hold = $urandom_range(1, 40);
			end
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= 1'b0;
			endcase
		end
	end

	// Watchdog: too many cycles in a row without any beat moving ends the run.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("** binomial_tree_gather_schedule_top: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Wait until every rank has been taken and every predicted beat has come,
	// then let the pipeline settle.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_ranks.size() != 0 || s_axis_tvalid || schedule_beats.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input btg_pkg::cfg_index_t idx,
			input logic [btg_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			btg_pkg::CFG_COMM_SIZE:  shadow_comm_size  = value[btg_pkg::SIZE_W-1:0];
			btg_pkg::CFG_ROOT_RANK:  shadow_root_rank  = value[btg_pkg::RANK_W-1:0];
			btg_pkg::CFG_RECV_COUNT: shadow_recv_count = value[btg_pkg::CNT_W-1:0];
			btg_pkg::CFG_SEND_COUNT: shadow_send_count = value[btg_pkg::CNT_W-1:0];
			default: ;
		endcase
	endtask

	// Registers change only once the block has gone quiet.
	task automatic set_config(input logic [btg_pkg::CFG_DATA_W-1:0] size_val,
			input logic [btg_pkg::CFG_DATA_W-1:0] root_val,
			input logic [btg_pkg::CFG_DATA_W-1:0] recv_val,
			input logic [btg_pkg::CFG_DATA_W-1:0] send_val);
		wait_drained();
		write_reg(btg_pkg::CFG_COMM_SIZE, size_val);
		write_reg(btg_pkg::CFG_ROOT_RANK, root_val);
		write_reg(btg_pkg::CFG_RECV_COUNT, recv_val);
		write_reg(btg_pkg::CFG_SEND_COUNT, send_val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [btg_pkg::CFG_DATA_W-1:0] random_count();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return btg_pkg::CFG_DATA_W'($urandom_range(1, 16));
			default: return btg_pkg::CFG_DATA_W'($urandom());
		endcase
	endfunction

	// One random phase: a fresh configuration, then ranks that mostly lie
	// inside the group, with the root itself and raw 10-bit ranks mixed in.
	task automatic random_phase(input int n_items);
		logic [btg_pkg::CFG_DATA_W-1:0] size_val, root_val;
		int unsigned size;
		int k;
		case ($urandom_range(0, 5))
			0: size_val = btg_pkg::CFG_DATA_W'($urandom_range(1, 8));
			1: size_val = btg_pkg::CFG_DATA_W'($urandom_range(9, 64));
			2: size_val = btg_pkg::CFG_DATA_W'($urandom_range(65, 1024));
			3: size_val = 16'd1024;
			4: size_val = btg_pkg::CFG_DATA_W'($urandom());
			default: size_val = btg_pkg::CFG_DATA_W'($urandom_range(0, 2047));
		endcase
		size = effective_size(size_val[btg_pkg::SIZE_W-1:0]);
		root_val = ($urandom_range(0, 1) == 0)
			? btg_pkg::CFG_DATA_W'($urandom_range(0, size - 1))
			: btg_pkg::CFG_DATA_W'($urandom());
		set_config(size_val, root_val, random_count(), random_count());
		for (k = 0; k < n_items; k++) begin
			case ($urandom_range(0, 9))
				7: queue_rank(shadow_root_rank);
				8, 9: queue_rank(btg_pkg::RANK_W'($urandom_range(0, 1023)));
				default: queue_rank(btg_pkg::RANK_W'($urandom_range(0, size - 1)));
			endcase
		end
	endtask

	initial begin
		int p;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values: a single rank, so only the completion beat comes out,
		// also for a rank far outside the group.
		queue_rank(10'd0);
		queue_rank(10'd1023);

		// Full group with the largest counts: the root has ten children and
		// gives the longest schedule; 1023 is a leaf that only sends.
		set_config(16'd1024, 16'd0, 16'hFFFF, 16'hFFFF);
		queue_rank(10'd0);
		queue_rank(10'd512);
		queue_rank(10'd1);
		queue_rank(10'd1023);
		queue_rank(10'd768);

		// A size of zero counts as one; the root is reduced modulo the size.
		set_config(16'd0, 16'h03FF, 16'd1, 16'd2);
		queue_rank(10'd0);
		queue_rank(10'd5);

		// Size above the maximum saturates; root at the top rank.
		set_config(16'd2047, 16'd1023, 16'd3, 16'hFFFF);
		queue_rank(10'd1022);
		queue_rank(10'd0);
		queue_rank(10'd1023);
		queue_rank(10'd511);

		// Odd group size with the root in the middle: truncated subtrees,
		// wrap-around of absolute ranks and out-of-range requests.
		set_config(16'd13, 16'd7, 16'h1234, 16'hABCD);
		queue_rank(10'd7);
		queue_rank(10'd8);
		queue_rank(10'd6);
		queue_rank(10'd12);
		queue_rank(10'd0);
		queue_rank(10'd3);
		queue_rank(10'd20);
		queue_rank(10'd1023);

		// Two ranks, with upper data bits set on the size and root writes.
		set_config(16'hF802, 16'hFC01, 16'd0, 16'hFFFF);
		queue_rank(10'd1);
		queue_rank(10'd0);

		// Each phase boundary holds the sender until the block has drained.
		for (p = 0; p < RANDOM_PHASES; p++)
			random_phase(PHASE_ITEMS);

		wait_drained();
		repeat (20) @(posedge clk);
		if (schedule_beats.size() != 0)
			$display("%0t: %0d expected beats never arrived", $time, schedule_beats.size());
		if (mismatches == 0 && schedule_beats.size() == 0) begin
			$display("** binomial_tree_gather_schedule_top: PASSED **");
		end else begin
			$display("** binomial_tree_gather_schedule_top: FAILED **");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/btg_pkg.sv
hw/rtl/btg_front.sv
hw/rtl/btg_queue.sv
hw/rtl/btg_back.sv
hw/rtl/binomial_tree_gather_schedule_top.sv
bench/testbench.sv
